[rtl/core/k_way_merge_min_heap_defines.svh]
// ---------------------------------------------------------------------------
// k_way_merge_min_heap_defines.svh
// Assertion macros shared by the merge heap modules.
// ---------------------------------------------------------------------------
// Both macros expect clk and arst_n to be visible in the using module.
`ifndef K_WAY_MERGE_MIN_HEAP_DEFINES_SVH
`define K_WAY_MERGE_MIN_HEAP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KWM_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KWM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/kwm_pkg.sv]
// ---------------------------------------------------------------------------
// kwm_pkg
// Types, codes and the key ordering shared by the merge heap modules.
// ---------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

	localparam int OCC_W = 5;

	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_POP     = 2'd1;
	localparam logic [1:0] OP_REPLACE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [31:0] value;
		logic [3:0]         list;
	} kwm_entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_UP,
		S_DOWN,
		S_EMIT
	} kwm_state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic up;
		logic down;
		logic emit;
	} kwm_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic up_stop;
		logic down_stop;
	} kwm_flags_t;

	// a precedes b: smaller value first, lower list number on a tie
	function automatic logic key_less(input kwm_entry_t a, input kwm_entry_t b);
		logic res;
		if ($signed(a.value) != $signed(b.value)) begin
			res = $signed(a.value) < $signed(b.value);
		end else begin
			res = a.list < b.list;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[rtl/core/kwm_datapath.sv]
// ---------------------------------------------------------------------------
// kwm_datapath
// Heap store, sift hole logic, entry count and result registers.
// ---------------------------------------------------------------------------
`default_nettype none
`include "k_way_merge_min_heap_defines.svh"

module kwm_datapath import kwm_pkg::*; #(
	parameter int LISTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kwm_cmd_t           cmd,
	output kwm_flags_t              flags,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [31:0] element_value,
	input  wire logic [3:0]         source_list,
	output logic signed [31:0]      min_value,
	output logic [3:0]              min_source,
	output logic [1:0]              status,
	output logic [OCC_W-1:0]        occupancy
);

	localparam int IW = (LISTS > 1) ? $clog2(LISTS) : 1;
	localparam int CW = $clog2(LISTS + 1);
	localparam int KW = CW + 1;

	kwm_entry_t mem [LISTS];
	kwm_entry_t rd0_q, rd1_q;
	logic [IW-1:0] ra0, ra1, wa;
	logic          we;
	kwm_entry_t    wd;

	kwm_entry_t    x_q, res_q;
	logic [1:0]    res_st_q;
	logic [IW-1:0] hole_q;
	logic [CW-1:0] count_q;
	logic          pop_q;

	logic signed [31:0] min_value_q;
	logic [3:0]         min_source_q;
	logic [1:0]         status_q;
	logic [OCC_W-1:0]   occupancy_q;

	logic is_push, is_pop, is_repl, full, empty;
	kwm_entry_t new_entry;
	logic [CW-1:0] push_parent, last_idx;
	logic [IW-1:0] parent, grand;
	logic up_stop;
	logic [KW-1:0] left_k, right_k, child_k;
	logic [IW-1:0] child;
	logic [IW:0]   next_l, next_r;
	logic left_ok, right_ok, take_left, take_right, down_stop;
	kwm_entry_t child_e;

	assign is_push   = (opcode == OP_PUSH);
	assign is_pop    = (opcode == OP_POP);
	assign is_repl   = (opcode == OP_REPLACE);
	assign full      = (count_q >= CW'(LISTS));
	assign empty     = (count_q == '0);
	assign new_entry = '{value: element_value, list: source_list};

	assign push_parent = (count_q - 1'b1) >> 1;
	assign last_idx    = count_q - 1'b1;

	// sift up: hole climbs while the held entry beats its parent
	assign parent  = (hole_q - 1'b1) >> 1;
	assign grand   = (parent - 1'b1) >> 1;
	assign up_stop = (hole_q == '0) || !key_less(x_q, rd0_q);

	// sift down: rd0 is the left child, rd1 the right child of the hole
	assign left_k     = KW'({hole_q, 1'b1});
	assign right_k    = left_k + 1'b1;
	assign left_ok    = left_k < KW'(count_q);
	assign right_ok   = right_k < KW'(count_q);
	assign take_left  = left_ok && key_less(rd0_q, x_q);
	assign take_right = right_ok && (take_left ? key_less(rd1_q, rd0_q) : key_less(rd1_q, x_q));
	assign down_stop  = !take_left && !take_right;
	assign child_k    = take_right ? right_k : left_k;
	assign child      = child_k[IW-1:0];
	assign child_e    = take_right ? rd1_q : rd0_q;
	assign next_l     = {child, 1'b1};
	assign next_r     = next_l + 1'b1;

	assign flags = '{full: full, empty: empty, up_stop: up_stop, down_stop: down_stop};

	always_comb begin
		ra0 = '0;
		ra1 = '0;
		we  = 1'b0;
		wa  = hole_q;
		wd  = x_q;
		if (cmd.accept) begin
			if (is_push) begin
				ra0 = push_parent[IW-1:0];
			end else begin
				ra1 = last_idx[IW-1:0];
			end
		end else if (cmd.load) begin
			ra0 = IW'(1);
			ra1 = IW'(2);
		end else if (cmd.up) begin
			ra0 = grand;
			we  = 1'b1;
			wd  = up_stop ? x_q : rd0_q;
		end else if (cmd.down) begin
			ra0 = next_l[IW-1:0];
			ra1 = next_r[IW-1:0];
			we  = 1'b1;
			wd  = down_stop ? x_q : child_e;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hole_q  <= '0;
			pop_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				pop_q <= is_pop;
				if (is_push && !full) begin
					count_q <= count_q + 1'b1;
					hole_q  <= count_q[IW-1:0];
				end else if (is_pop && !empty) begin
					count_q <= count_q - 1'b1;
				end
			end else if (cmd.load) begin
				hole_q <= '0;
			end else if (cmd.up && !up_stop) begin
				hole_q <= parent;
			end else if (cmd.down && !down_stop) begin
				hole_q <= child;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q   <= new_entry;
			res_q <= '0;
			if (is_push && full) begin
				res_st_q <= ST_FULL;
			end else if ((is_pop || is_repl) && empty) begin
				res_st_q <= ST_EMPTY;
			end else begin
				res_st_q <= ST_OK;
			end
		end else if (cmd.load) begin
			res_q <= rd0_q;
			x_q   <= pop_q ? rd1_q : kwm_entry_t'{value: x_q.value, list: rd0_q.list};
		end
		if (cmd.emit) begin
			min_value_q  <= res_q.value;
			min_source_q <= res_q.list;
			status_q     <= res_st_q;
			occupancy_q  <= OCC_W'(count_q);
		end
	end

	assign min_value  = min_value_q;
	assign min_source = min_source_q;
	assign status     = status_q;
	assign occupancy  = occupancy_q;

	`KWM_ASSERT(a_count_range, 1'b1, count_q <= CW'(LISTS), "entry count above capacity")
	`KWM_ASSERT(a_up_hole, cmd.up, CW'(hole_q) < count_q, "sift-up hole outside the heap")
	`KWM_ASSERT(a_down_hole, cmd.down && !empty, CW'(hole_q) < count_q, "sift-down hole astray")

endmodule

`default_nettype wire

[rtl/core/kwm_ctrl.sv]
// ---------------------------------------------------------------------------
// kwm_ctrl
// Operation sequencer and result handshake for the merge heap.
// ---------------------------------------------------------------------------
`default_nettype none
`include "k_way_merge_min_heap_defines.svh"

module kwm_ctrl import kwm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic [1:0] opcode,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	input  wire kwm_flags_t flags,
	output kwm_cmd_t        cmd
);

	kwm_state_t state_q, state_d;
	logic       rsp_valid_q;
	logic       out_free;
	logic       emit_wait;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign emit_wait = (state_q == S_EMIT) && !out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (opcode)
						OP_PUSH:             state_d = flags.full ? S_EMIT : S_UP;
						OP_POP, OP_REPLACE:  state_d = flags.empty ? S_EMIT : S_LOAD;
						default:             state_d = S_EMIT;
					endcase
				end
			end
			S_LOAD: state_d = S_DOWN;
			S_UP: begin
				if (flags.up_stop) state_d = S_EMIT;
			end
			S_DOWN: begin
				if (flags.down_stop) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && req_valid;
		cmd.load   = (state_q == S_LOAD);
		cmd.up     = (state_q == S_UP);
		cmd.down   = (state_q == S_DOWN);
		cmd.emit   = (state_q == S_EMIT) && out_free;
		req_stall  = (state_q != S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	`KWM_ASSERT_NEXT(a_accept_busy, cmd.accept, state_q != S_IDLE, "accepted word left no work")
	`KWM_ASSERT_NEXT(a_emit_hold, emit_wait, state_q == S_EMIT, "result lost while stalled")
	`KWM_ASSERT(a_rise_emit, $rose(rsp_valid_q), $past(state_q == S_EMIT), "stray result word")

endmodule

`default_nettype wire

[rtl/core/k_way_merge_min_heap.sv]
// ---------------------------------------------------------------------------
// k_way_merge_min_heap
// Min-heap of list heads for a k-way merge of sorted lists.
// ---------------------------------------------------------------------------
// One operation word is taken at a time. A push runs from acceptance through
// the sift-up state, where the new entry climbs one level per step, to the
// emit state; a pop or pop_replace first passes the load state, which takes
// the root and the last entry, then the sift-down state, where the hole
// descends one level per step; a push on a full heap, a pop on an empty one
// and the unused opcode go straight to the emit state. The sift loop is shaped
// by the heap store, which has one write and two registered read ports: each
// step of the loop compares the held entry against one parent or two children
// and moves the hole one level. The result word sits in an output register,
// so a stalled result does not hold the heap store busy once the operation
// has emitted it.
// ---------------------------------------------------------------------------
`default_nettype none

module k_way_merge_min_heap import kwm_pkg::*; #(
	parameter int LISTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [31:0] element_value,
	input  wire logic [3:0]         source_list,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic signed [31:0]      min_value,
	output logic [3:0]              min_source,
	output logic [1:0]              status,
	output logic [OCC_W-1:0]        occupancy
);

	// command and status between sequencer and datapath
	kwm_cmd_t   cmd;
	kwm_flags_t flags;

	// sequencer: decode the word, walk the sift loop, hand off the result
	kwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.opcode    (opcode),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.flags     (flags),
		.cmd       (cmd)
	);

	// datapath: heap store, hole index, count and result word
	kwm_datapath #(
		.LISTS (LISTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.flags         (flags),
		.opcode        (opcode),
		.element_value (element_value),
		.source_list   (source_list),
		.min_value     (min_value),
		.min_source    (min_source),
		.status        (status),
		.occupancy     (occupancy)
	);

endmodule

`default_nettype wire

[bench/tb_k_way_merge_min_heap.sv]
// ---------------------------------------------------------------------------
// tb_k_way_merge_min_heap
// Self-checking bench for the k-way merge min-heap.
// ---------------------------------------------------------------------------
// Every accepted request word updates a private heap of (value, list) keys.
// That heap yields the reply the block owes for the word. Replies are
// compared in order against the queue of owed replies. A short directed
// sequence hits empty and full heaps, ties, extreme values and the unused
// opcode. Random words then follow, shaped like a real merge: heads are
// pushed, and the minimum is replaced by a successor that is not smaller.
// Both sides of the handshake idle at random, and the bench drains the
// block once in the middle.
// ---------------------------------------------------------------------------

module tb_k_way_merge_min_heap import kwm_pkg::*;;

	localparam int          HEAP_DEPTH   = 16;
	localparam int          IDLE_LIMIT   = 4000;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          PHASE_WORDS  = 200;
	localparam int          REPORT_MAX   = 10;
	localparam logic [1:0]  OP_NOP       = 2'd3;

	typedef struct packed {
		logic signed [31:0] value;
		logic [3:0]         list;
		logic [1:0]         st;
		logic [OCC_W-1:0]   occ;
	} heap_reply_t;

	// -----------------------------------------------------------------------
	// Scoreboard: shadow heap plus the queue of replies still owed
	// -----------------------------------------------------------------------
	class heap_scoreboard;
		kwm_entry_t   slots [HEAP_DEPTH];
		int unsigned  fill;
		heap_reply_t  replies_due [$];
		int unsigned  faults;
		int unsigned  checked;
		int unsigned  full_drops;
		int unsigned  empty_pops;
		int unsigned  nops;

		function new();
			fill       = 0;
			faults     = 0;
			checked    = 0;
			full_drops = 0;
			empty_pops = 0;
			nops       = 0;
		endfunction

		// smaller signed value wins; a tie goes to the lower list number
		function bit precedes(kwm_entry_t a, kwm_entry_t b);
			if ($signed(a.value) != $signed(b.value))
				return $signed(a.value) < $signed(b.value);
			return a.list < b.list;
		endfunction

		function void swap_slots(int unsigned i, int unsigned j);
			kwm_entry_t t;
			t        = slots[i];
			slots[i] = slots[j];
			slots[j] = t;
		endfunction

		function logic signed [31:0] min_value();
			return slots[0].value;
		endfunction

		function heap_reply_t predict_reply(logic [1:0] op, logic signed [31:0] val,
				logic [3:0] src);
			heap_reply_t r;
			int unsigned i, lc, rc, best;
			r = '0;
			r.st = ST_OK;
			case (op)
				OP_PUSH: begin
					if (fill >= HEAP_DEPTH) begin
						r.st = ST_FULL;
						full_drops++;
					end else begin
						slots[fill].value = val;
						slots[fill].list  = src;
						i = fill;
						fill++;
						while (i > 0 && precedes(slots[i], slots[(i - 1) / 2])) begin
							swap_slots(i, (i - 1) / 2);
							i = (i - 1) / 2;
						end
					end
				end
				OP_POP, OP_REPLACE: begin
					if (fill == 0) begin
						r.st = ST_EMPTY;
						empty_pops++;
					end else begin
						r.value = slots[0].value;
						r.list  = slots[0].list;
						if (op == OP_POP) begin
							fill--;
							slots[0] = slots[fill];
						end else begin
							slots[0].value = val;
						end
						i = 0;
						while (1) begin
							lc   = 2 * i + 1;
							rc   = lc + 1;
							best = i;
							if (lc < fill && precedes(slots[lc], slots[best]))
								best = lc;
							if (rc < fill && precedes(slots[rc], slots[best]))
								best = rc;
							if (best == i)
								break;
							swap_slots(i, best);
							i = best;
						end
					end
				end
				default: nops++;
			endcase
			r.occ = fill[OCC_W-1:0];
			return r;
		endfunction

		function void note_word(logic [1:0] op, logic signed [31:0] val, logic [3:0] src);
			replies_due = {replies_due, predict_reply(op, val, src)};
		endfunction

		function void check_word(logic signed [31:0] value, logic [3:0] list, logic [1:0] st,
				logic [OCC_W-1:0] occ);
			heap_reply_t want;
			if (replies_due.size() == 0) begin
				if (faults < REPORT_MAX)
					$display("%t: unexpected reply value %0d list %0d status %0d occ %0d",
						$realtime, value, list, st, occ);
				faults++;
				return;
			end
			want = replies_due.pop_front();
			checked++;
			if (value !== want.value || list !== want.list || st !== want.st
					|| occ !== want.occ) begin
				if (faults < REPORT_MAX)
					$display("%t: reply %0d wrong: want %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
						$realtime, checked, want.value, want.list, want.st, want.occ,
						value, list, st, occ);
				faults++;
			end
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// Clock, reset and block ports; every input known from time zero
	// -----------------------------------------------------------------------
	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    req_valid     = 1'b0;
	logic                    req_stall;
	logic [1:0]              opcode        = OP_PUSH;
	logic signed [31:0]      element_value = '0;
	logic [3:0]              source_list   = '0;
	logic                    rsp_valid;
	logic                    rsp_stall     = 1'b0;
	logic signed [31:0]      min_value;
	logic [3:0]              min_source;
	logic [1:0]              status;
	logic [OCC_W-1:0]        occupancy;

	int unsigned             tx_idle_pct   = 30;
	int unsigned             rx_idle_pct   = 48;
	int unsigned             words_sent    = 0;
	int unsigned             idle_run      = 0;
	bit                      draining      = 1'b0;

	heap_scoreboard sb = new();

	always #4 clk = ~clk;

	k_way_merge_min_heap #(
		.LISTS(HEAP_DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.opcode       (opcode),
		.element_value(element_value),
		.source_list  (source_list),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.min_value    (min_value),
		.min_source   (min_source),
		.status       (status),
		.occupancy    (occupancy)
	);

	// -----------------------------------------------------------------------
	// Reply side: check every reply that is taken, then pick the next stall.
	// Outputs are read at the edge, before the block's own updates land.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_word(min_value, min_source, status, occupancy);
		rsp_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Watchdog: count edges on which neither side moves a word; give up
	// once the count reaches the limit.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_run <= 0;
			end else if (idle_run + 1 >= IDLE_LIMIT) begin
				$display("%t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end else begin
				idle_run <= idle_run + 1;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Request side
	// -----------------------------------------------------------------------

	// Present one word and hold it until the block takes it. Idle gaps go in
	// front of the word, so valid is lowered at most once per edge and stays
	// up across back-to-back words.
	task automatic send_word(input logic [1:0] op, input logic signed [31:0] val,
			input logic [3:0] src);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid     <= 1'b1;
		opcode        <= op;
		element_value <= val;
		source_list   <= src;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_word(op, val, src);
		words_sent++;
	endtask

	// Hold valid low until the block owes nothing.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(posedge clk);
	endtask

	// Small values from -8 to 8 in three picks of eight, so ties between lists
	// turn up often; the rest are the extremes or the whole 32-bit range.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7fff_ffff;
					2:       return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			1, 2, 3: return 32'($urandom_range(16)) - 32'sd8;
			default: return $urandom;
		endcase
	endfunction

	// Next element of a sorted list: never below the current head; clamp at
	// the top of the range rather than wrap.
	function automatic logic signed [31:0] successor_of(logic signed [31:0] head);
		longint s;
		s = longint'(head) + longint'($urandom_range(20));
		if (s > 64'sd2147483647)
			s = 64'sd2147483647;
		return s[31:0];
	endfunction

	task automatic run_directed();
		int k;
		// empty heap: both pop kinds report empty, then the unused opcode
		send_word(OP_POP,     32'sd0,        4'd0);
		send_word(OP_REPLACE, -32'sd1,       4'd15);
		send_word(OP_NOP,     32'sh7fff_ffff, 4'd5);
		// extremes of value and list, then a tie on value
		send_word(OP_PUSH,    32'sd0,        4'd0);
		send_word(OP_PUSH,    32'sh7fff_ffff, 4'd15);
		send_word(OP_PUSH,    32'sh8000_0000, 4'd7);
		send_word(OP_PUSH,    -32'sd1,       4'd3);
		send_word(OP_PUSH,    32'sd5,        4'd9);
		send_word(OP_PUSH,    32'sd5,        4'd2);
		// replace the most negative head so three lists tie on 5
		send_word(OP_REPLACE, 32'sd5,        4'd0);
		// fill up, with more ties, then push into a full heap
		for (k = 0; k < 10; k++)
			send_word(OP_PUSH, (k % 3) - 1, 4'(15 - k));
		send_word(OP_PUSH,    -32'sd1,       4'd15);
		send_word(OP_NOP,     32'sd0,        4'd0);
		send_word(OP_POP,     32'sd0,        4'd0);
		send_word(OP_POP,     32'sd0,        4'd15);
		send_word(OP_REPLACE, 32'sh8000_0000, 4'd0);
	endtask

	// Merge-like traffic: grow towards full, then shrink towards empty. A
	// few words in each hundred are plain noise with any opcode.
	task automatic run_random(input int n);
		int               i;
		int unsigned      r;
		logic [1:0]       op;
		logic signed [31:0] val;
		logic [3:0]       src;
		for (i = 0; i < n; i++) begin
			if (sb.fill == HEAP_DEPTH && $urandom_range(2) == 0)
				draining = 1'b1;
			else if (sb.fill == 0 && $urandom_range(1) == 0)
				draining = 1'b0;
			src = 4'($urandom_range(15));
			val = pick_value();
			r   = $urandom_range(99);
			if (r < 8) begin
				op = 2'($urandom_range(3));
			end else begin
				r = $urandom_range(99);
				if (!draining)
					op = (r < 55) ? OP_PUSH : (r < 85) ? OP_REPLACE : OP_POP;
				else
					op = (r < 55) ? OP_POP : (r < 85) ? OP_REPLACE : OP_PUSH;
				if (op == OP_REPLACE && sb.fill != 0 && $urandom_range(9) < 7)
					val = successor_of(sb.min_value());
			end
			send_word(op, val, src);
		end
	endtask

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles 30 %, receiver 48 %
		run_directed();
		run_random(PHASE_WORDS);

		// let the block run dry once before swapping the idle rates
		wait_for_drain();
		tx_idle_pct = 48;
		rx_idle_pct = 30;
		run_random(PHASE_WORDS);

		// neither side idles
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(PHASE_WORDS);

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d request words and %0d checked replies,", words_sent,
			sb.checked);
		$display("with %0d pushes on a full heap, %0d pops on an empty one, %0d no-ops.",
			sb.full_drops, sb.empty_pops, sb.nops);
		if (sb.faults == 0 && sb.replies_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
